@@ design/lad_pkg.sv @@
// Shared types and constants for the linear array deque.
package lad_pkg;

    localparam int DEPTH_DEF      = 32;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        REQ_PUSH_BACK  = 2'd0,
        REQ_PUSH_FRONT = 2'd1,
        REQ_POP_BACK   = 2'd2,
        REQ_POP_FRONT  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SHIFT,
        ST_FILL,
        ST_RESULT
    } state_t;

    typedef enum logic [2:0] {
        DP_NONE,
        DP_PUSH,
        DP_POP,
        DP_SHIFT_START,
        DP_SHIFT_STEP,
        DP_SHIFT_FILL
    } dp_op_t;

    typedef struct packed {
        logic    load_req;
        dp_op_t  op;
        logic    load_out;
        status_t out_code;
        logic    out_take_data;
    } lad_cmd_t;

    typedef struct packed {
        req_t req_type;
        logic occupied;
        logic at_limit;
        logic shift_last;
    } lad_stat_t;

endpackage

@@ design/linear_array_deque.sv @@
// Top level: linear array double-ended queue, controller plus datapath.
// Flow: request registered, executed in EXEC, result loaded in RESULT; push front
//   onto held entries first passes SHIFT (one slot moved per cycle, one read and one
//   write port) and FILL. No new request is taken before that load; a result
//   that is not taken holds the next one back. s_ready is high only while idle.
// Reset: aresetn synchronous active low empties the queue; slots are not cleared.
module linear_array_deque #(
    parameter int DEPTH      = lad_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = lad_pkg::DATA_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_req_type,
    input  logic [DATA_WIDTH-1:0]        s_item_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_status,
    output logic [DATA_WIDTH-1:0]        m_out_data,
    output logic                         m_is_empty,
    output logic                         m_is_full,
    output logic [$clog2(DEPTH+1)-1:0]   m_held_count
);
    import lad_pkg::*;

    lad_cmd_t  cmd;
    lad_stat_t stat;

    lad_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    lad_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_req_type   (s_req_type),
        .s_item_data  (s_item_data),
        .cmd          (cmd),
        .stat         (stat),
        .m_status     (m_status),
        .m_out_data   (m_out_data),
        .m_is_empty   (m_is_empty),
        .m_is_full    (m_is_full),
        .m_held_count (m_held_count)
    );

endmodule

@@ design/lad_datapath.sv @@
// Datapath: slot memory, front/rear indices, shift pointer and result registers.
module lad_datapath #(
    parameter int DEPTH      = lad_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = lad_pkg::DATA_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [1:0]                   s_req_type,
    input  logic [DATA_WIDTH-1:0]        s_item_data,
    input  lad_pkg::lad_cmd_t            cmd,
    output lad_pkg::lad_stat_t           stat,
    output logic [1:0]                   m_status,
    output logic [DATA_WIDTH-1:0]        m_out_data,
    output logic                         m_is_empty,
    output logic                         m_is_full,
    output logic [$clog2(DEPTH+1)-1:0]   m_held_count
);
    import lad_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [IDX_W-1:0]      front_reg, front_next;
    logic [IDX_W-1:0]      rear_reg, rear_next;
    logic                  occupied_reg, occupied_next;
    logic [IDX_W-1:0]      ptr_reg, ptr_next;
    req_t                  req_type_reg;
    logic [DATA_WIDTH-1:0] req_data_reg;
    logic [DATA_WIDTH-1:0] rd_data_reg;

    logic [1:0]            status_reg;
    logic [DATA_WIDTH-1:0] out_data_reg;
    logic                  empty_reg;
    logic                  full_reg;
    logic [CNT_W-1:0]      count_reg;

    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic                  at_limit;
    logic [IDX_W-1:0]      ptr_dec;
    logic [IDX_W-1:0]      span;

    assign at_limit = occupied_reg && (rear_reg == LAST_IDX);
    assign ptr_dec  = ptr_reg - IDX_W'(1);
    assign span     = rear_reg - front_reg;

    assign stat.req_type   = req_type_reg;
    assign stat.occupied   = occupied_reg;
    assign stat.at_limit   = at_limit;
    assign stat.shift_last = (ptr_reg == front_reg + IDX_W'(1));

    always_comb begin
        front_next    = front_reg;
        rear_next     = rear_reg;
        occupied_next = occupied_reg;
        ptr_next      = ptr_reg;
        wr_en         = 1'b0;
        wr_addr       = rear_reg;
        wr_data       = req_data_reg;
        rd_en         = 1'b0;
        rd_addr       = front_reg;
        unique case (cmd.op)
            DP_NONE: begin
            end
            DP_PUSH: begin
                wr_en = 1'b1;
                if (occupied_reg) begin
                    rear_next = rear_reg + IDX_W'(1);
                    wr_addr   = rear_reg + IDX_W'(1);
                end else begin
                    front_next    = '0;
                    rear_next     = '0;
                    occupied_next = 1'b1;
                    wr_addr       = '0;
                end
            end
            DP_POP: begin
                rd_en   = 1'b1;
                rd_addr = (req_type_reg == REQ_POP_BACK) ? rear_reg : front_reg;
                if (front_reg == rear_reg) begin
                    front_next    = '0;
                    rear_next     = '0;
                    occupied_next = 1'b0;
                end else if (req_type_reg == REQ_POP_BACK) begin
                    rear_next = rear_reg - IDX_W'(1);
                end else begin
                    front_next = front_reg + IDX_W'(1);
                end
            end
            DP_SHIFT_START: begin
                rd_en    = 1'b1;
                rd_addr  = rear_reg;
                ptr_next = rear_reg + IDX_W'(1);
            end
            DP_SHIFT_STEP: begin
                wr_en    = 1'b1;
                wr_addr  = ptr_reg;
                wr_data  = rd_data_reg;
                rd_en    = 1'b1;
                rd_addr  = ptr_dec - IDX_W'(1);
                ptr_next = ptr_dec;
            end
            DP_SHIFT_FILL: begin
                wr_en     = 1'b1;
                wr_addr   = front_reg;
                rear_next = rear_reg + IDX_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg    <= '0;
            rear_reg     <= '0;
            occupied_reg <= 1'b0;
        end else begin
            front_reg    <= front_next;
            rear_reg     <= rear_next;
            occupied_reg <= occupied_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg <= ptr_next;
        if (cmd.load_req) begin
            req_type_reg <= req_t'(s_req_type);
            req_data_reg <= s_item_data;
        end
        if (cmd.load_out) begin
            status_reg   <= cmd.out_code;
            out_data_reg <= cmd.out_take_data ? rd_data_reg : '0;
            empty_reg    <= !occupied_reg;
            full_reg     <= at_limit;
            count_reg    <= occupied_reg ? (CNT_W'(span) + CNT_W'(1)) : '0;
        end
    end

    assign m_status     = status_reg;
    assign m_out_data   = out_data_reg;
    assign m_is_empty   = empty_reg;
    assign m_is_full    = full_reg;
    assign m_held_count = count_reg;

endmodule

@@ design/lad_controller.sv @@
// Controller: request sequencing state machine and result valid.
module lad_controller (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  lad_pkg::lad_stat_t  stat,
    output lad_pkg::lad_cmd_t   cmd
);
    import lad_pkg::*;

    state_t  state_reg, state_next;
    status_t code_reg, code_next;
    logic    take_reg, take_next;
    logic    m_valid_reg, m_valid_next;
    logic    out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            code_reg    <= STAT_OK;
            take_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            code_reg    <= code_next;
            take_reg    <= take_next;
        end
    end

    always_comb begin
        state_next        = state_reg;
        code_next         = code_reg;
        take_next         = take_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        cmd.load_req      = 1'b0;
        cmd.op            = DP_NONE;
        cmd.load_out      = 1'b0;
        cmd.out_code      = code_reg;
        cmd.out_take_data = take_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC: begin
                take_next  = 1'b0;
                code_next  = STAT_OK;
                state_next = ST_RESULT;
                unique case (stat.req_type) inside
                    REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
                        if (stat.at_limit) begin
                            code_next = STAT_FULL;
                        end else if (stat.req_type == REQ_PUSH_FRONT && stat.occupied) begin
                            cmd.op     = DP_SHIFT_START;
                            state_next = ST_SHIFT;
                        end else begin
                            cmd.op = DP_PUSH;
                        end
                    end
                    REQ_POP_BACK, REQ_POP_FRONT: begin
                        if (!stat.occupied) begin
                            code_next = STAT_EMPTY;
                        end else begin
                            cmd.op    = DP_POP;
                            take_next = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_SHIFT: begin
                cmd.op = DP_SHIFT_STEP;
                if (stat.shift_last) begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL: begin
                cmd.op     = DP_SHIFT_FILL;
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/lad_checker.sv @@
// Port-level checker for the linear array deque, bound to the top level.
module lad_checker #(
    parameter int DEPTH      = lad_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = lad_pkg::DATA_WIDTH_DEF
) (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [1:0]                   m_status,
    input logic [DATA_WIDTH-1:0]        m_out_data,
    input logic                         m_is_empty,
    input logic                         m_is_full,
    input logic [$clog2(DEPTH+1)-1:0]   m_held_count
);
    import lad_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_out_data)
            && $stable(m_held_count))
        else $error("result changed while stalled");

    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_is_empty == (m_held_count == '0)) && !(m_is_empty && m_is_full))
        else $error("empty flag disagrees with count");

    a_empty_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STAT_EMPTY |-> m_is_empty && m_out_data == '0)
        else $error("rejected pop with data or non-empty queue");

    a_full_push: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STAT_FULL |-> m_is_full && m_out_data == '0)
        else $error("rejected push on non-full queue");

    a_one_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while busy");

endmodule

bind linear_array_deque lad_checker #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
) u_lad_checker (.*);
